// ===== rtl/core/gcdb_pkg.sv =====
// ----------------------------------------------------------------------------
// Great-circle distance package
// Field widths, fixed-point constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package gcdb_pkg;

    localparam int LON_W  = 31;
    localparam int LAT_W  = 30;
    localparam int DIST_W = 25;
    localparam int HEAD_W = 25;

    localparam int ANG_W  = 34;
    localparam int RED_W  = 36;
    localparam int CS_W   = 33;
    localparam int PROD_W = 2 * CS_W;
    localparam int A_W    = 61;
    localparam int RT_W   = 31;
    localparam int AT_W   = 34;
    localparam int ATI_W  = 36;
    localparam int AZ_W   = 34;
    localparam int TBL_W  = 30;

    localparam int SQ_STEPS = 32;
    localparam int SQ_W     = 63;

    localparam logic signed [RED_W-1:0] Q30_PI      = 36'sd3373259426;
    localparam logic signed [RED_W-1:0] Q30_HALF_PI = 36'sd1686629713;
    localparam logic signed [RED_W-1:0] Q30_TWO_PI  = 36'sd6746518852;
    localparam logic signed [CS_W-1:0]  CORDIC_GAIN = 33'sd652032874;
    localparam logic [A_W-1:0]          A_ONE       = 61'd1 << 60;
    localparam logic [23:0]             DIAMETER_M  = 24'd12742000;
    localparam logic signed [28:0]      DEG_SCALE   = 29'sd240315917;
    localparam logic [27:0]             FULL_TURN   = 28'd23592960;
    localparam logic [26:0]             DIST_MAX    = 27'd20015087;

    function automatic logic [TBL_W-1:0] atan_q30(input logic [4:0] idx);
        logic [TBL_W-1:0] val;
        unique case (idx)
            5'd0:  val = 30'd843314857;
            5'd1:  val = 30'd497837829;
            5'd2:  val = 30'd263043837;
            5'd3:  val = 30'd133525159;
            5'd4:  val = 30'd67021687;
            5'd5:  val = 30'd33543516;
            5'd6:  val = 30'd16775851;
            5'd7:  val = 30'd8388437;
            5'd8:  val = 30'd4194283;
            5'd9:  val = 30'd2097149;
            5'd10: val = 30'd1048576;
            5'd11: val = 30'd524288;
            5'd12: val = 30'd262144;
            5'd13: val = 30'd131072;
            5'd14: val = 30'd65536;
            5'd15: val = 30'd32768;
            5'd16: val = 30'd16384;
            5'd17: val = 30'd8192;
            5'd18: val = 30'd4096;
            5'd19: val = 30'd2048;
            5'd20: val = 30'd1024;
            5'd21: val = 30'd512;
            5'd22: val = 30'd256;
            5'd23: val = 30'd128;
            5'd24: val = 30'd64;
            5'd25: val = 30'd32;
            5'd26: val = 30'd16;
            5'd27: val = 30'd8;
            5'd28: val = 30'd4;
            5'd29: val = 30'd2;
            5'd30: val = 30'd1;
            5'd31: val = 30'd0;
        endcase
        return val;
    endfunction

endpackage

// ===== rtl/core/gcdb_pair_if.sv =====
// ----------------------------------------------------------------------------
// Point pair channel
// Valid/ready channel that carries one pair of points per item.
// ----------------------------------------------------------------------------
interface gcdb_pair_if;
    logic                                valid;
    logic                                ready;
    logic signed [gcdb_pkg::LON_W-1:0]   start_lon;
    logic signed [gcdb_pkg::LAT_W-1:0]   start_lat;
    logic signed [gcdb_pkg::LON_W-1:0]   end_lon;
    logic signed [gcdb_pkg::LAT_W-1:0]   end_lat;

    modport source (output valid, output start_lon, output start_lat,
                    output end_lon, output end_lat, input ready);
    modport sink (input valid, input start_lon, input start_lat,
                  input end_lon, input end_lat, output ready);
endinterface

// ===== rtl/core/gcdb_result_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one distance and heading per item.
// ----------------------------------------------------------------------------
interface gcdb_result_if;
    logic                             valid;
    logic                             ready;
    logic [gcdb_pkg::DIST_W-1:0]      distance_m;
    logic [gcdb_pkg::HEAD_W-1:0]      heading;

    modport source (output valid, output distance_m, output heading, input ready);
    modport sink (input valid, input distance_m, input heading, output ready);
endinterface

// ===== rtl/core/great_circle_distance_bearing.sv =====
// Throughput: one pair per cycle; every stage is a register and stalls only when the
// result register is full, not taken, and the stage before it also holds an item.
// The depth is set by the two CORDIC chains and the 32-stage square root.
// Reset clears all valid bits; the data path registers are not reset.
// ----------------------------------------------------------------------------
// Great-circle distance and initial bearing
// Haversine distance in meters and initial heading in 1/65536 degree.
// ----------------------------------------------------------------------------
module great_circle_distance_bearing #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic          clk,
    input  logic          rst_n,
    gcdb_pair_if.sink     pair,
    gcdb_result_if.source result
);
    import gcdb_pkg::*;

    localparam int SIDE_W = 2 * AT_W;

    logic en;
    logic out_free;

    // Input stage: angle differences and scaled latitudes.
    logic signed [ANG_W-1:0] lon0_x, lat0_x, lon1_x, lat1_x;
    logic signed [ANG_W-1:0] hlat_reg, hlon_reg, dlon_reg, lat0_reg, lat1_reg;
    logic                    s0_v_reg;

    assign lon0_x = ANG_W'(pair.start_lon);
    assign lat0_x = ANG_W'(pair.start_lat);
    assign lon1_x = ANG_W'(pair.end_lon);
    assign lat1_x = ANG_W'(pair.end_lat);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_v_reg <= pair.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hlat_reg <= (lat1_x - lat0_x) <<< 1;
            hlon_reg <= (lon1_x - lon0_x) <<< 1;
            dlon_reg <= (lon1_x - lon0_x) <<< 2;
            lat0_reg <= lat0_x <<< 2;
            lat1_reg <= lat1_x <<< 2;
        end
    end

    logic signed [CS_W-1:0] s_hlat, s_hlon, sdlon, cdlon;
    logic signed [CS_W-1:0] slat0, clat0, slat1, clat1;
    logic [4:0]             sc_v;

    gcdb_sincos #(.STEPS(CORDIC_STEPS)) u_sc_hlat (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s0_v_reg), .angle(hlat_reg),
        .out_valid(sc_v[0]), .sin_q(s_hlat), .cos_q());
    gcdb_sincos #(.STEPS(CORDIC_STEPS)) u_sc_hlon (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s0_v_reg), .angle(hlon_reg),
        .out_valid(sc_v[1]), .sin_q(s_hlon), .cos_q());
    gcdb_sincos #(.STEPS(CORDIC_STEPS)) u_sc_dlon (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s0_v_reg), .angle(dlon_reg),
        .out_valid(sc_v[2]), .sin_q(sdlon), .cos_q(cdlon));
    gcdb_sincos #(.STEPS(CORDIC_STEPS)) u_sc_lat0 (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s0_v_reg), .angle(lat0_reg),
        .out_valid(sc_v[3]), .sin_q(slat0), .cos_q(clat0));
    gcdb_sincos #(.STEPS(CORDIC_STEPS)) u_sc_lat1 (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s0_v_reg), .angle(lat1_reg),
        .out_valid(sc_v[4]), .sin_q(slat1), .cos_q(clat1));

    // First products.
    logic signed [PROD_W-1:0] p_cc, p_hs, p_hlat, p_y, p_t1, p_t2;
    logic signed [CS_W-1:0]   cc_reg, hs_reg, by_reg, t1_reg, t2_reg, cdlon_reg;
    logic signed [PROD_W-1:0] p1_reg;
    logic                     m1_v_reg;

    assign p_cc   = clat0 * clat1;
    assign p_hs   = s_hlon * s_hlon;
    assign p_hlat = s_hlat * s_hlat;
    assign p_y    = sdlon * clat1;
    assign p_t1   = clat0 * slat1;
    assign p_t2   = slat0 * clat1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_v_reg <= 1'b0;
        end
        else if (en)
        begin
            m1_v_reg <= &sc_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cc_reg    <= p_cc[CS_W+29:30];
            hs_reg    <= p_hs[CS_W+29:30];
            p1_reg    <= p_hlat;
            by_reg    <= p_y[CS_W+29:30];
            t1_reg    <= p_t1[CS_W+29:30];
            t2_reg    <= p_t2[CS_W+29:30];
            cdlon_reg <= cdlon;
        end
    end

    // Second products.
    logic signed [PROD_W-1:0] q_reg, u_reg, p1d_reg;
    logic signed [CS_W-1:0]   byd_reg, t1d_reg;
    logic                     m2_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m2_v_reg <= 1'b0;
        end
        else if (en)
        begin
            m2_v_reg <= m1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg   <= cc_reg * hs_reg;
            u_reg   <= t2_reg * cdlon_reg;
            p1d_reg <= p1_reg;
            byd_reg <= by_reg;
            t1d_reg <= t1_reg;
        end
    end

    // Haversine term with clamp, and the bearing vector.
    logic signed [PROD_W-1:0] a_sum;
    logic signed [PROD_W-1:0] u_shift;
    logic [A_W-1:0]           a_clamp;
    logic [A_W-1:0]           a_reg;
    logic signed [AT_W-1:0]   bx_reg, bye_reg;
    logic                     m3_v_reg;

    assign a_sum   = p1d_reg + q_reg;
    assign u_shift = u_reg >>> 30;

    always_comb
    begin
        if (a_sum[PROD_W-1])
        begin
            a_clamp = '0;
        end
        else if (a_sum > PROD_W'(A_ONE))
        begin
            a_clamp = A_ONE;
        end
        else
        begin
            a_clamp = a_sum[A_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m3_v_reg <= 1'b0;
        end
        else if (en)
        begin
            m3_v_reg <= m2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg   <= a_clamp;
            bx_reg  <= AT_W'(t1d_reg) - AT_W'(u_shift);
            bye_reg <= AT_W'(byd_reg);
        end
    end

    // Square roots of a and 1 - a; the bearing vector rides alongside.
    logic [RT_W-1:0]   ra, rb;
    logic [SIDE_W-1:0] side_q;
    logic              sq_v;

    gcdb_isqrt #(.SIDE_W(SIDE_W)) u_sqrt_a (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(m3_v_reg), .radicand(a_reg),
        .side_in({bye_reg, bx_reg}), .out_valid(sq_v), .root(ra), .side_out(side_q));
    gcdb_isqrt #(.SIDE_W(1)) u_sqrt_b (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(m3_v_reg), .radicand(A_ONE - a_reg),
        .side_in(1'b0), .out_valid(), .root(rb), .side_out());

    logic signed [AZ_W-1:0] z_dist, z_head;
    logic                   at_v;

    gcdb_atan2 #(.STEPS(CORDIC_STEPS)) u_at_dist (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(sq_v),
        .y_in($signed(AT_W'(ra))), .x_in($signed(AT_W'(rb))),
        .out_valid(at_v), .angle(z_dist));
    gcdb_atan2 #(.STEPS(CORDIC_STEPS)) u_at_head (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(sq_v),
        .y_in($signed(side_q[SIDE_W-1:AT_W])), .x_in($signed(side_q[AT_W-1:0])),
        .out_valid(), .angle(z_head));

    // Scaling to meters and degrees.
    logic [AZ_W-2:0]    zd;
    logic [56:0]        pd_reg;
    logic signed [62:0] ph_reg;
    logic               f1_v_reg;

    assign zd = z_dist[AZ_W-1] ? '0 : z_dist[AZ_W-2:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_v_reg <= 1'b0;
        end
        else if (en)
        begin
            f1_v_reg <= at_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pd_reg <= 57'(DIAMETER_M) * 57'(zd);
            ph_reg <= 63'(z_head) * 63'(DEG_SCALE);
        end
    end

    // Rounding.
    logic [57:0]  dsum;
    logic [62:0]  hmag_abs;
    logic [62:0]  hsum;
    logic [26:0]  dist_reg;
    logic [26:0]  hm_reg;
    logic         hneg_reg;
    logic         f2_v_reg;

    assign dsum     = 58'(pd_reg) + (58'd1 << 29);
    assign hmag_abs = ph_reg[62] ? 63'(-ph_reg) : 63'(ph_reg);
    assign hsum     = hmag_abs + (63'd1 << 35);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f2_v_reg <= 1'b0;
        end
        else if (en)
        begin
            f2_v_reg <= f1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dist_reg <= (dsum[57:30] > 28'(DIST_MAX)) ? DIST_MAX : dsum[56:30];
            hm_reg   <= hsum[62:36];
            hneg_reg <= ph_reg[62];
        end
    end

    // Heading wrap and result register.
    logic [27:0]       hm_ext;
    logic [HEAD_W-1:0] head_wrap;
    logic [DIST_W-1:0] dist_out_reg;
    logic [HEAD_W-1:0] head_out_reg;
    logic              out_v_reg;

    assign hm_ext = 28'(hm_reg);

    always_comb
    begin
        if (hneg_reg && (hm_ext != '0))
        begin
            head_wrap = (hm_ext > FULL_TURN) ? '0 : HEAD_W'(FULL_TURN - hm_ext);
        end
        else if (hm_ext >= FULL_TURN)
        begin
            head_wrap = HEAD_W'(hm_ext - FULL_TURN);
        end
        else
        begin
            head_wrap = HEAD_W'(hm_ext);
        end
    end

    assign out_free = !out_v_reg || result.ready;
    assign en       = out_free || !f2_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_v_reg <= f2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            dist_out_reg <= dist_reg[DIST_W-1:0];
            head_out_reg <= head_wrap;
        end
    end

    assign pair.ready        = en;
    assign result.valid      = out_v_reg;
    assign result.distance_m = dist_out_reg;
    assign result.heading    = head_out_reg;

endmodule

// ===== rtl/core/gcdb_sincos.sv =====
// ----------------------------------------------------------------------------
// Pipelined CORDIC sine and cosine
// Range reduction and quadrant fold, then one rotation per stage.
// ----------------------------------------------------------------------------
module gcdb_sincos #(
    parameter int STEPS = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic signed [gcdb_pkg::ANG_W-1:0]   angle,
    output logic                                out_valid,
    output logic signed [gcdb_pkg::CS_W-1:0]    sin_q,
    output logic signed [gcdb_pkg::CS_W-1:0]    cos_q
);
    import gcdb_pkg::*;

    logic signed [RED_W-1:0] ang_ext;
    logic signed [RED_W-1:0] ang_red;
    logic signed [RED_W-1:0] ang_fold;
    logic                    fold_neg;

    logic signed [CS_W-1:0]  x_reg [0:STEPS];
    logic signed [CS_W-1:0]  y_reg [0:STEPS];
    logic signed [CS_W-1:0]  z_reg [0:STEPS];
    logic                    neg_reg [0:STEPS];
    logic                    v_reg [0:STEPS];
    logic signed [CS_W-1:0]  sin_reg;
    logic signed [CS_W-1:0]  cos_reg;
    logic                    out_v_reg;

    always_comb
    begin
        ang_ext = RED_W'(angle);
        if (ang_ext > Q30_PI)
        begin
            ang_red = ang_ext - Q30_TWO_PI;
        end
        else if (ang_ext < -Q30_PI)
        begin
            ang_red = ang_ext + Q30_TWO_PI;
        end
        else
        begin
            ang_red = ang_ext;
        end
        if (ang_red > Q30_HALF_PI)
        begin
            ang_fold = Q30_PI - ang_red;
            fold_neg = 1'b1;
        end
        else if (ang_red < -Q30_HALF_PI)
        begin
            ang_fold = -Q30_PI - ang_red;
            fold_neg = 1'b1;
        end
        else
        begin
            ang_fold = ang_red;
            fold_neg = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]   <= CORDIC_GAIN;
            y_reg[0]   <= '0;
            z_reg[0]   <= CS_W'(ang_fold);
            neg_reg[0] <= fold_neg;
        end
    end

    for (genvar i = 0; i < STEPS; i++)
    begin : g_rot
        localparam logic signed [CS_W-1:0] ATI = CS_W'(atan_q30(5'(i)));
        logic signed [CS_W-1:0] dx;
        logic signed [CS_W-1:0] dy;
        assign dx = x_reg[i] >>> i;
        assign dy = y_reg[i] >>> i;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                neg_reg[i+1] <= neg_reg[i];
                if (!z_reg[i][CS_W-1])
                begin
                    x_reg[i+1] <= x_reg[i] - dy;
                    y_reg[i+1] <= y_reg[i] + dx;
                    z_reg[i+1] <= z_reg[i] - ATI;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + dy;
                    y_reg[i+1] <= y_reg[i] - dx;
                    z_reg[i+1] <= z_reg[i] + ATI;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            out_v_reg <= v_reg[STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_reg <= y_reg[STEPS];
            cos_reg <= neg_reg[STEPS] ? -x_reg[STEPS] : x_reg[STEPS];
        end
    end

    assign out_valid = out_v_reg;
    assign sin_q     = sin_reg;
    assign cos_q     = cos_reg;

endmodule

// ===== rtl/core/gcdb_isqrt.sv =====
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Restoring digit-by-digit root, one result bit per stage, with side data.
// ----------------------------------------------------------------------------
module gcdb_isqrt #(
    parameter int SIDE_W = 68
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic [gcdb_pkg::A_W-1:0]         radicand,
    input  logic [SIDE_W-1:0]                side_in,
    output logic                             out_valid,
    output logic [gcdb_pkg::RT_W-1:0]        root,
    output logic [SIDE_W-1:0]                side_out
);
    import gcdb_pkg::*;

    logic [A_W-1:0]    v_reg [0:SQ_STEPS];
    logic [SQ_W-1:0]   r_reg [0:SQ_STEPS];
    logic [SIDE_W-1:0] side_reg [0:SQ_STEPS];
    logic              val_reg [0:SQ_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            val_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg[0]    <= radicand;
            r_reg[0]    <= '0;
            side_reg[0] <= side_in;
        end
    end

    for (genvar j = 0; j < SQ_STEPS; j++)
    begin : g_digit
        localparam logic [SQ_W-1:0] ONE = SQ_W'(1) << (2 * (SQ_STEPS - 1 - j));
        logic [SQ_W-1:0] trial;
        logic            take;
        assign trial = r_reg[j] + ONE;
        assign take  = SQ_W'(v_reg[j]) >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                val_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                val_reg[j+1] <= val_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[j+1] <= side_reg[j];
                if (take)
                begin
                    v_reg[j+1] <= v_reg[j] - trial[A_W-1:0];
                    r_reg[j+1] <= (r_reg[j] >> 1) + ONE;
                end
                else
                begin
                    v_reg[j+1] <= v_reg[j];
                    r_reg[j+1] <= r_reg[j] >> 1;
                end
            end
        end
    end

    assign out_valid = val_reg[SQ_STEPS];
    assign root      = r_reg[SQ_STEPS][RT_W-1:0];
    assign side_out  = side_reg[SQ_STEPS];

endmodule

// ===== rtl/core/gcdb_atan2.sv =====
// ----------------------------------------------------------------------------
// Pipelined CORDIC arctangent
// Half-plane fold, then one vectoring step per stage; zero vector gives zero.
// ----------------------------------------------------------------------------
module gcdb_atan2 #(
    parameter int STEPS = 24
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic signed [gcdb_pkg::AT_W-1:0]   y_in,
    input  logic signed [gcdb_pkg::AT_W-1:0]   x_in,
    output logic                               out_valid,
    output logic signed [gcdb_pkg::AZ_W-1:0]   angle
);
    import gcdb_pkg::*;

    logic signed [ATI_W-1:0] xe;
    logic signed [ATI_W-1:0] ye;
    logic signed [ATI_W-1:0] x_fold;
    logic signed [ATI_W-1:0] y_fold;
    logic signed [AZ_W-1:0]  z_fold;

    logic signed [ATI_W-1:0] x_reg [0:STEPS];
    logic signed [ATI_W-1:0] y_reg [0:STEPS];
    logic signed [AZ_W-1:0]  z_reg [0:STEPS];
    logic                    zero_reg [0:STEPS];
    logic                    v_reg [0:STEPS];

    always_comb
    begin
        xe = ATI_W'(x_in);
        ye = ATI_W'(y_in);
        if (xe < 0)
        begin
            if (ye >= 0)
            begin
                x_fold = ye;
                y_fold = -xe;
                z_fold = AZ_W'(Q30_HALF_PI);
            end
            else
            begin
                x_fold = -ye;
                y_fold = xe;
                z_fold = -AZ_W'(Q30_HALF_PI);
            end
        end
        else
        begin
            x_fold = xe;
            y_fold = ye;
            z_fold = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= x_fold;
            y_reg[0]    <= y_fold;
            z_reg[0]    <= z_fold;
            zero_reg[0] <= (x_in == '0) && (y_in == '0);
        end
    end

    for (genvar i = 0; i < STEPS; i++)
    begin : g_vec
        localparam logic signed [AZ_W-1:0] ATI = AZ_W'(atan_q30(5'(i)));
        logic signed [ATI_W-1:0] dx;
        logic signed [ATI_W-1:0] dy;
        assign dx = x_reg[i] >>> i;
        assign dy = y_reg[i] >>> i;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                zero_reg[i+1] <= zero_reg[i];
                if (!y_reg[i][ATI_W-1])
                begin
                    x_reg[i+1] <= x_reg[i] + dy;
                    y_reg[i+1] <= y_reg[i] - dx;
                    z_reg[i+1] <= z_reg[i] + ATI;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - dy;
                    y_reg[i+1] <= y_reg[i] + dx;
                    z_reg[i+1] <= z_reg[i] - ATI;
                end
            end
        end
    end

    assign out_valid = v_reg[STEPS];
    assign angle     = zero_reg[STEPS] ? '0 : z_reg[STEPS];

endmodule
